/* design/tsv_pkg.sv */
// Package for the topic string validator: item type, character codes and
// the reserved prefix table. No dependencies.
package tsv_pkg;

  localparam int unsigned PrefixLen = 7;
  localparam int unsigned PrefixW   = 3;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] PrintLo = 8'h20;
  localparam logic [7:0] PrintHi = 8'h7E;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       sub_pattern;
    logic       empty_topic;
  } item_t;

  typedef struct packed {
    logic fire;
    logic verdict;
  } res_t;

  function automatic logic [7:0] prefix_char(input logic [PrefixW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h65;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h70;
      3'd3:    c = 8'h6E;
      3'd4:    c = 8'h6F;
      3'd5:    c = 8'h77;
      3'd6:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/tsv_ifs.sv */
// Handshake interfaces for the topic string validator channels.
// Depends on nothing.
interface tsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  logic       sub_pattern;
  logic       empty_topic;

  modport source (output valid, ch, last, sub_pattern, empty_topic, input ready);
  modport sink   (input valid, ch, last, sub_pattern, empty_topic, output ready);
endinterface

interface tsv_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, valid_res, input ready);
  modport sink   (input valid, valid_res, output ready);
endinterface

/* design/tsv_checker.sv */
// Per-topic rule state and checks; one character item per step.
// Depends on tsv_pkg.
module tsv_checker #(
  parameter int unsigned MAX_TOPIC_LEN = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  tsv_pkg::item_t item,
  output tsv_pkg::res_t  res
);

  localparam int unsigned CntW = $clog2(MAX_TOPIC_LEN + 2);
  localparam logic [CntW-1:0] MaxLen = CntW'(MAX_TOPIC_LEN);
  localparam logic [tsv_pkg::PrefixW-1:0] PrefixEnd =
    tsv_pkg::PrefixLen[tsv_pkg::PrefixW-1:0];

  logic [CntW-1:0]             char_count, char_count_next;
  logic [tsv_pkg::PrefixW-1:0] prefix_matched, prefix_matched_next;
  logic prefix_broken, prefix_broken_next;
  logic prev_slash, prev_slash_next;
  logic prev_plus, prev_plus_next;
  logic failed, failed_next;
  logic pattern_mode, pattern_mode_next;

  logic first, pat, fail, is_slash, is_plus, clear;

  always_comb begin
    first = (char_count == '0);
    pat   = first ? item.sub_pattern : pattern_mode;
    is_slash = (item.ch == tsv_pkg::ChSlash);
    is_plus  = (item.ch == tsv_pkg::ChPlus);
    fail  = failed;

    char_count_next = (char_count <= MaxLen) ? char_count + 1'b1 : char_count;
    if (char_count_next > MaxLen) fail = 1'b1;

    prefix_matched_next = prefix_matched;
    prefix_broken_next  = prefix_broken;
    if (!prefix_broken && prefix_matched < PrefixEnd) begin
      if (item.ch == tsv_pkg::prefix_char(prefix_matched)) begin
        prefix_matched_next = prefix_matched + 1'b1;
        if (prefix_matched_next == PrefixEnd) fail = 1'b1;
      end else begin
        prefix_broken_next = 1'b1;
      end
    end

    if (item.ch < tsv_pkg::PrintLo || item.ch > tsv_pkg::PrintHi) fail = 1'b1;
    if (is_slash && (first || prev_slash || item.last)) fail = 1'b1;
    if (item.ch == tsv_pkg::ChHash) fail = 1'b1;
    if (prev_plus && !is_slash) fail = 1'b1;
    if (is_plus && (!pat || !(first || prev_slash))) fail = 1'b1;

    prev_plus_next    = is_plus && pat;
    prev_slash_next   = is_slash;
    pattern_mode_next = pat;
    failed_next       = fail;

    clear       = item.empty_topic || item.last;
    res.fire    = step && clear;
    res.verdict = !item.empty_topic && !fail;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      char_count     <= '0;
      prefix_matched <= '0;
      prefix_broken  <= 1'b0;
      prev_slash     <= 1'b0;
      prev_plus      <= 1'b0;
      failed         <= 1'b0;
      pattern_mode   <= 1'b0;
    end else if (step) begin
      char_count     <= char_count_next;
      prefix_matched <= prefix_matched_next;
      prefix_broken  <= prefix_broken_next;
      prev_slash     <= prev_slash_next;
      prev_plus      <= prev_plus_next;
      failed         <= failed_next;
      pattern_mode   <= pattern_mode_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    step && clear |=> char_count == '0 && !failed && !prefix_broken)
    else $error("state not cleared after topic end");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= MaxLen + 1'b1)
    else $error("character count past saturation");

  a_prefix_fails: assert property (@(posedge clk) disable iff (rst)
    prefix_matched == PrefixEnd |-> failed)
    else $error("reserved prefix not flagged");

  a_pass_in_bounds: assert property (@(posedge clk) disable iff (rst)
    res.fire && res.verdict |-> char_count < MaxLen && !failed)
    else $error("pass verdict on overlong or failed topic");

endmodule

/* design/tsv_out_reg.sv */
// Result register driving the verdict channel.
// Depends on tsv_pkg and tsv_ifs.
module tsv_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  tsv_pkg::res_t res,
  output logic          free,
  tsv_out_if.source     verdict
);

  logic out_vld;
  logic out_res;

  assign free            = !out_vld || verdict.ready;
  assign verdict.valid     = out_vld;
  assign verdict.valid_res = out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (free) begin
      out_vld <= res.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res.fire) begin
      out_res <= res.verdict;
    end
  end

endmodule

/* design/topic_string_validator.sv */
// Topic string validator top level: input register, rule checker, result register.
// Depends on tsv_pkg, tsv_ifs, tsv_checker and tsv_out_reg.
//
//   port     | dir | payload                                 | one item is
//   ---------+-----+-----------------------------------------+---------------------
//   topic    | in  | ch[7:0], last, sub_pattern, empty_topic | one topic character
//   verdict  | out | valid_res                               | one verdict per topic
//
// One character per cycle, save where a stalled verdict holds back a topic end.
// The last character lands in the input register, the checker judges it and the
// verdict is loaded into the result register as soon as that register is free.
// Reset (rst, synchronous) clears the topic state and both registers. Only an item
// that ends a topic needs the result register; a stalled verdict holds back just
// such an item (and input behind it), while middle characters keep flowing.
module topic_string_validator #(
  parameter int unsigned MAX_TOPIC_LEN = 64
) (
  input logic       clk,
  input logic       rst,
  tsv_in_if.sink    topic,
  tsv_out_if.source verdict
);

  logic           in_vld;
  tsv_pkg::item_t in_q;
  tsv_pkg::res_t  res;
  logic           free;
  logic           adv;

  assign adv         = in_vld && (!(in_q.last || in_q.empty_topic) || free);
  assign topic.ready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (topic.ready) begin
      in_vld <= topic.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (topic.ready && topic.valid) begin
      in_q <= '{ch: topic.ch, last: topic.last, sub_pattern: topic.sub_pattern,
                 empty_topic: topic.empty_topic};
    end
  end

  tsv_checker #(
    .MAX_TOPIC_LEN(MAX_TOPIC_LEN)
  ) u_checker (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .item (in_q),
    .res  (res)
  );

  tsv_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .res     (res),
    .free    (free),
    .verdict (verdict)
  );

endmodule

/* verif/tsv_verdict_checker.sv */
// Verdict checker for the topic string validator: watches both channels,
// predicts the verdict of every topic and compares it with what comes out.
// Depends on tsv_pkg and tsv_ifs.
module tsv_verdict_checker #(
  parameter int unsigned MAX_TOPIC_LEN = 64
) (
  input  logic clk,
  input  logic rst,
  tsv_in_if    topic,
  tsv_out_if   verdict,
  output int   errors,
  output int   pending
);

  localparam logic [8*tsv_pkg::PrefixLen-1:0] Reserved = 56'h65_73_70_6E_6F_77_2F;

  int unsigned                 char_cnt;
  logic [tsv_pkg::PrefixW-1:0] pfx_hits;
  logic                        pfx_off;
  logic                        after_slash;
  logic                        after_plus;
  logic                        broken;
  logic                        pat_mode;

  bit verdict_q[$];
  int err_cnt;

  task automatic clear_topic();
    char_cnt    = 0;
    pfx_hits    = '0;
    pfx_off     = 1'b0;
    after_slash = 1'b0;
    after_plus  = 1'b0;
    broken      = 1'b0;
    pat_mode    = 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Advance the topic rules by one character; done marks a verdict.
  task automatic judge_char(input tsv_pkg::item_t it, output bit done, output bit ok);
    bit first;
    bit bad;
    logic [7:0] want_ch;
    done = 1'b0;
    ok   = 1'b0;
    if (it.empty_topic) begin
      done = 1'b1;
      clear_topic();
      return;
    end
    first = (char_cnt == 0);
    bad   = broken;
    if (first) pat_mode = it.sub_pattern;
    if (char_cnt <= MAX_TOPIC_LEN) char_cnt++;
    if (char_cnt > MAX_TOPIC_LEN) bad = 1'b1;
    if (!pfx_off && pfx_hits < tsv_pkg::PrefixLen) begin
      want_ch = Reserved[8*(tsv_pkg::PrefixLen-1-pfx_hits) +: 8];
      if (it.ch == want_ch) begin
        pfx_hits++;
        if (pfx_hits == tsv_pkg::PrefixLen) bad = 1'b1;
      end else begin
        pfx_off = 1'b1;
      end
    end
    if (it.ch < tsv_pkg::PrintLo || it.ch > tsv_pkg::PrintHi) bad = 1'b1;
    if (it.ch == tsv_pkg::ChSlash && (first || after_slash || it.last)) bad = 1'b1;
    if (it.ch == tsv_pkg::ChHash) bad = 1'b1;
    if (after_plus && it.ch != tsv_pkg::ChSlash) bad = 1'b1;
    if (it.ch == tsv_pkg::ChPlus && (!pat_mode || !(first || after_slash))) bad = 1'b1;
    after_plus  = (it.ch == tsv_pkg::ChPlus) && pat_mode;
    after_slash = (it.ch == tsv_pkg::ChSlash);
    broken      = bad;
    if (it.last) begin
      done = 1'b1;
      ok   = !bad;
      clear_topic();
    end
  endtask

  always @(posedge clk) begin
    tsv_pkg::item_t it;
    bit done, ok, want;
    if (rst) begin
      clear_topic();
    end else begin
      if (verdict.valid && verdict.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict %0b with none expected", verdict.valid_res));
        end else begin
          want = verdict_q.pop_front();
          if (verdict.valid_res !== want)
            report_mismatch($sformatf("valid_res %0b, expected %0b", verdict.valid_res, want));
        end
      end
      if (topic.valid && topic.ready) begin
        it.ch          = topic.ch;
        it.last        = topic.last;
        it.sub_pattern = topic.sub_pattern;
        it.empty_topic = topic.empty_topic;
        judge_char(it, done, ok);
        if (done) verdict_q.push_back(ok);
      end
    end
    errors  <= err_cnt;
    pending <= verdict_q.size();
  end

endmodule

/* verif/testbench.sv */
// Testbench top for the topic string validator: clock, reset, topic stimulus
// and a stalling verdict receiver; checking is done by tsv_verdict_checker.
// Depends on tsv_pkg, tsv_ifs, topic_string_validator and tsv_verdict_checker.
module testbench;

  localparam int unsigned MaxLen    = 64;
  localparam int          NumItems  = 1650;
  localparam int          CycleCap  = 300000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   sent;
  int   burst_left;
  int   stall_left = 0;
  int   stall_mode = 0;

  logic [7:0] topic_buf[$];

  tsv_in_if  topic_ch();
  tsv_out_if verdict_ch();

  topic_string_validator #(.MAX_TOPIC_LEN(MaxLen)) u_top (
    .clk     (clk),
    .rst     (rst),
    .topic   (topic_ch),
    .verdict (verdict_ch)
  );

  tsv_verdict_checker #(.MAX_TOPIC_LEN(MaxLen)) u_checker (
    .clk     (clk),
    .rst     (rst),
    .topic   (topic_ch),
    .verdict (verdict_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleCap) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: picks a new random stall mode whenever its hold counter runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    if (rst) begin
      verdict_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       verdict_ch.ready <= 1'b1;
        1:       verdict_ch.ready <= 1'($urandom_range(0, 1));
        2:       verdict_ch.ready <= ($urandom_range(0, 3) == 0);
        default: verdict_ch.ready <= (stall_left[2:0] != 3'd0);
      endcase
    end
  end

  function automatic logic [7:0] clean_char();
    logic [7:0] c;
    do c = 8'($urandom_range(tsv_pkg::PrintLo, tsv_pkg::PrintHi));
    while (c == tsv_pkg::ChSlash || c == tsv_pkg::ChHash || c == tsv_pkg::ChPlus);
    return c;
  endfunction

  function automatic void build_clean(input bit pat);
    int nseg;
    int len;
    topic_buf.delete();
    nseg = $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      if (s != 0) topic_buf.push_back(tsv_pkg::ChSlash);
      if (pat && $urandom_range(0, 2) == 0) begin
        topic_buf.push_back(tsv_pkg::ChPlus);
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) topic_buf.push_back(clean_char());
      end
    end
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic last, input logic pat,
                           input logic empty);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        topic_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    topic_ch.valid       <= 1'b1;
    topic_ch.ch          <= ch;
    topic_ch.last        <= last;
    topic_ch.sub_pattern <= pat;
    topic_ch.empty_topic <= empty;
    do @(posedge clk); while (!topic_ch.ready);
    sent++;
  endtask

  // Send topic_buf; without finish the topic is left open.
  task automatic send_topic(input bit pat, input bit finish);
    int n;
    n = topic_buf.size();
    for (int i = 0; i < n; i++)
      push_char(topic_buf[i], finish && (i == n - 1),
                (i == 0) ? pat : 1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic send_text(input string s, input bit pat);
    topic_buf.delete();
    for (int i = 0; i < s.len(); i++) topic_buf.push_back(s[i]);
    send_topic(pat, 1'b1);
  endtask

  task automatic send_empty();
    push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic random_topic();
    int kind;
    int k;
    int len;
    bit pat;
    logic [7:0] bad_ch;
    kind = $urandom_range(0, 99);
    pat  = 1'($urandom_range(0, 1));
    if (kind < 45) begin
      build_clean(pat);
      send_topic(pat, 1'b1);
    end else if (kind < 55) begin
      k = $urandom_range(1, tsv_pkg::PrefixLen);
      topic_buf.delete();
      for (int i = 0; i < k; i++) topic_buf.push_back(tsv_pkg::prefix_char(3'(i)));
      if ($urandom_range(0, 2) != 0) begin
        if (topic_buf[k-1] != tsv_pkg::ChSlash) topic_buf.push_back(tsv_pkg::ChSlash);
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) topic_buf.push_back(clean_char());
      end
      if ($urandom_range(0, 3) == 0) topic_buf[$urandom_range(0, k-1)] = clean_char();
      send_topic(pat, 1'b1);
    end else if (kind < 70) begin
      build_clean(pat);
      case ($urandom_range(0, 6))
        0:       bad_ch = tsv_pkg::ChSlash;
        1:       bad_ch = tsv_pkg::ChHash;
        2:       bad_ch = tsv_pkg::ChPlus;
        3:       bad_ch = 8'h00;
        4:       bad_ch = 8'h7F;
        5:       bad_ch = 8'h1F;
        default: bad_ch = 8'($urandom_range(0, 255));
      endcase
      topic_buf[$urandom_range(0, topic_buf.size() - 1)] = bad_ch;
      send_topic(pat, 1'b1);
    end else if (kind < 75) begin
      build_clean(pat);
      if ($urandom_range(0, 1)) topic_buf.push_front(tsv_pkg::ChSlash);
      else topic_buf.push_back(tsv_pkg::ChSlash);
      send_topic(pat, 1'b1);
    end else if (kind < 80) begin
      topic_buf.delete();
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) topic_buf.push_back(8'($urandom_range(0, 255)));
      send_topic(pat, 1'b1);
    end else if (kind < 85) begin
      send_empty();
    end else if (kind < 90) begin
      build_clean(pat);
      send_topic(pat, 1'b0);
      send_empty();
    end else if (kind < 93) begin
      topic_buf.delete();
      len = $urandom_range(MaxLen - 2, MaxLen + 4);
      for (int i = 0; i < len; i++) topic_buf.push_back(clean_char());
      send_topic(pat, 1'b1);
    end else begin
      // '+' glued to neighbors or repeated
      build_clean(1'b1);
      k = $urandom_range(0, topic_buf.size());
      topic_buf.insert(k, tsv_pkg::ChPlus);
      send_topic(1'b1, 1'b1);
    end
  endtask

  initial begin
    bit paused;
    paused     = 1'b0;
    sent       = 0;
    burst_left = 0;
    rst                  <= 1'b1;
    topic_ch.valid       <= 1'b0;
    topic_ch.ch          <= '0;
    topic_ch.last        <= 1'b0;
    topic_ch.sub_pattern <= 1'b0;
    topic_ch.empty_topic <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    push_char(8'hFF, 1'b1, 1'b1, 1'b1);
    send_text("+", 1'b1);
    send_text("+", 1'b0);
    push_char(8'h00, 1'b1, 1'b0, 1'b0);
    push_char(8'hFF, 1'b1, 1'b0, 1'b0);
    push_char(tsv_pkg::PrintHi, 1'b1, 1'b0, 1'b0);
    push_char(tsv_pkg::PrintLo, 1'b1, 1'b0, 1'b0);
    push_char(tsv_pkg::PrintLo - 8'd1, 1'b1, 1'b0, 1'b0);
    push_char(tsv_pkg::PrintHi + 8'd1, 1'b1, 1'b0, 1'b0);
    send_text("#", 1'b0);
    send_text("a/+", 1'b1);
    send_text("+a", 1'b1);
    send_text("a//b", 1'b0);
    topic_buf.delete();
    for (int i = 0; i < tsv_pkg::PrefixLen; i++)
      topic_buf.push_back(tsv_pkg::prefix_char(3'(i)));
    send_topic(1'b0, 1'b1);

    while (sent < NumItems) begin
      if (!paused && sent >= NumItems / 2) begin
        paused = 1'b1;
        topic_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        burst_left = 1;
      end
      random_topic();
    end
    topic_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
